// File: rtl/sat_pkg.sv
package sat_pkg;

  // Default sizes, handed to the top level parameters
  localparam int MAX_WIDTH_DEF    = 2048;
  localparam int MAX_HEIGHT_DEF   = 2048;
  localparam int CHANNEL_BITS_DEF = 16;

  // Fixed field widths
  localparam int NUM_CHAN   = 4;
  localparam int PIX_W      = 16;
  localparam int SUM_W      = 38;
  localparam int CFG_DIM_W  = 12;
  localparam int DIM_CMP_W  = 14;   // holds any clamped size up to 8192
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CFG_DIM_W-1:0] RESET_DIM = 12'd2048;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef logic [SUM_W-1:0] sum_t;

  // Position flags of the pixel at the head of the raster
  typedef struct packed {
    logic first_col;
    logic top_row;
    logic last_pixel;
  } pos_flags_t;

endpackage

// File: rtl/sat_line_store.sv
module sat_line_store #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 152,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-before-write on a same-address collision; caller forwards
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sat_raster_counter.sv
module sat_raster_counter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sat_pkg::CFG_DIM_W-1:0]   img_width,
  input  logic [sat_pkg::CFG_DIM_W-1:0]   img_height,
  input  logic                            adv,
  output logic [COL_W-1:0]                col,
  output sat_pkg::pos_flags_t             flags
);

  localparam int DW = sat_pkg::DIM_CMP_W;
  localparam logic [DW-1:0] MAXW = DW'(MAX_WIDTH);
  localparam logic [DW-1:0] MAXH = DW'(MAX_HEIGHT);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DW-1:0]    w_eff, h_eff, w_ext, h_ext, col_inc, row_inc;
  logic             last_col, last_row;

  assign w_ext = DW'(img_width);
  assign h_ext = DW'(img_height);

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    priority if (w_ext == '0) w_eff = DW'(1);
    else if (w_ext > MAXW)    w_eff = MAXW;
    else                      w_eff = w_ext;
    priority if (h_ext == '0) h_eff = DW'(1);
    else if (h_ext > MAXH)    h_eff = MAXH;
    else                      h_eff = h_ext;
  end

  assign col_inc  = DW'(col_r) + DW'(1);
  assign row_inc  = DW'(row_r) + DW'(1);
  assign last_col = (col_inc >= w_eff);
  assign last_row = (row_inc >= h_eff);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (adv) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col              = col_r;
  assign flags.first_col  = (col_r == '0);
  assign flags.top_row    = (row_r == '0);
  assign flags.last_pixel = last_col && last_row;

endmodule

// File: rtl/summed_area_table_core.sv
// Summed-area table (integral image) generator. RGBA pixels enter in raster
// order on the in_ channel, one request per cycle when nothing stalls; each
// pixel yields one result on the out_ channel carrying, per channel, the sum
// of every pixel at or above its row and at or left of its column, plus a
// frame_end flag on the frame's last pixel. Sustained rate is one pixel per
// clock while the output does not stall; a taken pixel goes through the
// line-store read, then the add into the output register. The rate is set
// by the line store: one read and one write port on a single MAX_WIDTH-deep
// memory that holds the previous row's sums for all four channels. When a
// pixel reads the column the previous pixel is writing (image width one),
// the written value is forwarded. The line store has no reset and needs no
// clearing pass: row 0 ignores what it reads. Image width and height are set
// through the APB registers (0x0 width, 0x4 height, 12 bits, 0 acts as 1,
// values above the maximum clamp); write them only while the block is idle.
// Changing the size mid-frame does not restart the raster counters.
module summed_area_table_core #(
  parameter int MAX_WIDTH    = sat_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = sat_pkg::MAX_HEIGHT_DEF,
  parameter int CHANNEL_BITS = sat_pkg::CHANNEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel requests
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [sat_pkg::PIX_W-1:0]        in_red_in,
  input  logic [sat_pkg::PIX_W-1:0]        in_green_in,
  input  logic [sat_pkg::PIX_W-1:0]        in_blue_in,
  input  logic [sat_pkg::PIX_W-1:0]        in_alpha_in,
  // result requests
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sat_pkg::SUM_W-1:0]        out_red_sum,
  output logic [sat_pkg::SUM_W-1:0]        out_green_sum,
  output logic [sat_pkg::SUM_W-1:0]        out_blue_sum,
  output logic [sat_pkg::SUM_W-1:0]        out_alpha_sum,
  output logic                             out_frame_end,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sat_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sat_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sat_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int NCH     = sat_pkg::NUM_CHAN;
  localparam int SUM_W   = sat_pkg::SUM_W;
  localparam int PIX_W   = sat_pkg::PIX_W;
  localparam int DIM_W   = sat_pkg::CFG_DIM_W;
  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RUN_W   = CHANNEL_BITS + COL_W;   // one full row of max pixels
  localparam int PIX_USE = (CHANNEL_BITS < PIX_W) ? CHANNEL_BITS : PIX_W;
  localparam int LS_W    = NCH * SUM_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0] width_r, height_r;
  logic             cfg_wr;
  sat_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = sat_pkg::reg_idx_t'(paddr[sat_pkg::APB_ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sat_pkg::RESET_DIM;
      height_r <= sat_pkg::RESET_DIM;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sat_pkg::REG_IMAGE_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        sat_pkg::REG_IMAGE_HEIGHT: height_r <= pwdata[DIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sat_pkg::REG_IMAGE_WIDTH:  prdata = sat_pkg::APB_DATA_W'(width_r);
      sat_pkg::REG_IMAGE_HEIGHT: prdata = sat_pkg::APB_DATA_W'(height_r);
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: s1 holds the pixel waiting on its line-store read, the
  // output register holds the finished result.
  // ---------------------------------------------------------------------
  logic in_accept, s1_move;
  logic s1_valid_r, out_valid_r;

  assign s1_move   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_accept = in_valid && !in_stall;

  // Raster position of the pixel being taken
  logic [COL_W-1:0]    cur_col;
  sat_pkg::pos_flags_t cur_flags;

  sat_raster_counter #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cnt (
    .clk        (clk),
    .rst_n      (rst_n),
    .img_width  (width_r),
    .img_height (height_r),
    .adv        (in_accept),
    .col        (cur_col),
    .flags      (cur_flags)
  );

  // ---------------------------------------------------------------------
  // Stage 0: row running sum, line-store read issue
  // ---------------------------------------------------------------------
  logic [PIX_W-1:0] pix [NCH];
  logic [RUN_W-1:0] pix_m   [NCH];
  logic [RUN_W-1:0] run_r   [NCH];
  logic [RUN_W-1:0] run_nxt [NCH];

  assign pix[0] = in_red_in;
  assign pix[1] = in_green_in;
  assign pix[2] = in_blue_in;
  assign pix[3] = in_alpha_in;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      pix_m[c]   = RUN_W'(pix[c][PIX_USE-1:0]);
      run_nxt[c] = (cur_flags.first_col ? '0 : run_r[c]) + pix_m[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) run_r[c] <= '0;
    end else if (in_accept) begin
      for (int c = 0; c < NCH; c++) run_r[c] <= run_nxt[c];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: add the row above, write back, forward on collision
  // ---------------------------------------------------------------------
  logic [RUN_W-1:0]   s1_run_r [NCH];
  logic [COL_W-1:0]   s1_col_r;
  logic               s1_top_r, s1_end_r;
  logic               fwd_hit_r;
  sat_pkg::sum_t      fwd_data_r [NCH];
  sat_pkg::sum_t      s1_up  [NCH];
  sat_pkg::sum_t      s1_sum [NCH];
  logic [LS_W-1:0]    ls_wdata, ls_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int c = 0; c < NCH; c++) begin
        s1_run_r[c]   <= run_nxt[c];
        fwd_data_r[c] <= s1_sum[c];
      end
      s1_col_r  <= cur_col;
      s1_top_r  <= cur_flags.top_row;
      s1_end_r  <= cur_flags.last_pixel;
      // older pixel writes this column at the same edge the read is taken
      fwd_hit_r <= s1_move && (s1_col_r == cur_col);
    end
  end

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (s1_top_r) begin
        s1_up[c] = '0;
      end else if (fwd_hit_r) begin
        s1_up[c] = fwd_data_r[c];
      end else begin
        s1_up[c] = ls_rdata[c*SUM_W +: SUM_W];
      end
      s1_sum[c] = SUM_W'(s1_run_r[c]) + s1_up[c];
      ls_wdata[c*SUM_W +: SUM_W] = s1_sum[c];
    end
  end

  sat_line_store #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (LS_W)
  ) u_line (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col_r),
    .wdata (ls_wdata),
    .re    (in_accept),
    .raddr (cur_col),
    .rdata (ls_rdata)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  sat_pkg::sum_t out_sum_r [NCH];
  logic          out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      for (int c = 0; c < NCH; c++) out_sum_r[c] <= s1_sum[c];
      out_end_r <= s1_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_sum   = out_sum_r[0];
  assign out_green_sum = out_sum_r[1];
  assign out_blue_sum  = out_sum_r[2];
  assign out_alpha_sum = out_sum_r[3];
  assign out_frame_end = out_end_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // input is held off only when both stages are full and the sink stalls
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  // a pixel blocked in stage 1 stays put with its column
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_move) |=> (s1_valid_r && $stable(s1_col_r)))
    else $error("stage 1 pixel lost while blocked");

  // the frame's last pixel restarts the raster at the top-left corner
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && cur_flags.last_pixel) |=>
      (cur_col == '0 && cur_flags.top_row))
    else $error("raster did not wrap after frame end");

endmodule
